/* rtl/ods_pkg.sv */
// Shared types, constants and tables for the oscillator divider search.
// Used by ods_search, ods_divider and oscillator_divider_search.
package ods_pkg;

   // Field widths
   localparam int TARGET_W = 32;
   localparam int XTAL_W   = 32;
   localparam int HS_W     = 4;
   localparam int N1_W     = 8;
   localparam int MULT_W   = 11;   // hs * n1 up to 11 * 128 = 1408
   localparam int PROD_W   = 43;   // target * hs * n1
   localparam int DCO_W    = 34;
   localparam int RFREQ_W  = 38;
   localparam int FRAC_SHIFT = 31; // Q21 over Q24 into Q28

   // Crystal register after reset, about 114.285 MHz in Q8.24
   localparam logic [XTAL_W-1:0] XTAL_RESET = 32'd1917384131;

   // DCO window in Q21 MHz, both ends included
   localparam logic [PROD_W-1:0] DCO_MIN = 43'd4850 << 21;
   localparam logic [PROD_W-1:0] DCO_MAX = 43'd5670 << 21;

   // Scan limits
   localparam logic [N1_W-1:0] N1_FIRST = 8'd1;
   localparam logic [N1_W-1:0] N1_LAST  = 8'd128;
   localparam logic [2:0]      HS_LAST  = 3'd5;

   // Best pair found by the search
   typedef struct packed {
      logic             found;
      logic [HS_W-1:0]  hs;
      logic [N1_W-1:0]  n1;
      logic [DCO_W-1:0] dco;
   } best_type;

   // High-speed divider values in scan order: 11, 9, 7, 6, 5, 4
   function automatic logic [HS_W-1:0] hs_of(input logic [2:0] idx);
      logic [HS_W-1:0] val;
      case (idx)
         3'd0: val = 4'd11;
         3'd1: val = 4'd9;
         3'd2: val = 4'd7;
         3'd3: val = 4'd6;
         3'd4: val = 4'd5;
         default: val = 4'd4;
      endcase
      return val;
   endfunction

endpackage

/* rtl/ods_search.sv */
// Divider pair scan: steps through each HS with N1 = 1 and every even N1,
// one per cycle, in a three-stage multiply/compare pipeline. Depends on ods_pkg.
module ods_search (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ods_pkg::TARGET_W-1:0]     target_freq,
   output logic                             done,
   output ods_pkg::best_type                best
);

   logic [ods_pkg::TARGET_W-1:0] target_ff;

   // scan counters
   logic                     scan_ff, scan_in;
   logic [ods_pkg::N1_W-1:0] n_ff, n_in;
   logic [2:0]               k_ff, k_in;

   // stage A: divider product
   logic                       a_vld_ff, a_last_ff;
   logic [ods_pkg::MULT_W-1:0] a_mult_ff;
   logic [ods_pkg::HS_W-1:0]   a_hs_ff;
   logic [ods_pkg::N1_W-1:0]   a_n1_ff;

   // stage B: DCO product
   logic                       b_vld_ff, b_last_ff;
   logic [ods_pkg::PROD_W-1:0] b_dco_ff;
   logic [ods_pkg::HS_W-1:0]   b_hs_ff;
   logic [ods_pkg::N1_W-1:0]   b_n1_ff;

   ods_pkg::best_type best_ff, best_in;
   logic              done_ff, done_in;

   logic [ods_pkg::HS_W-1:0]      hs_cur;
   logic                          last_pair;
   logic [ods_pkg::HS_W+ods_pkg::N1_W-1:0] mult_full;
   logic                          in_window;
   logic                          better;

   assign hs_cur    = ods_pkg::hs_of(k_ff);
   assign last_pair = (n_ff == ods_pkg::N1_LAST) && (k_ff == ods_pkg::HS_LAST);
   assign mult_full = 12'(hs_cur) * 12'(n_ff);

   // window and ordering check on stage B
   assign in_window = (b_dco_ff >= ods_pkg::DCO_MIN) && (b_dco_ff <= ods_pkg::DCO_MAX);
   assign better    = !best_ff.found ||
                      (b_dco_ff < ods_pkg::PROD_W'(best_ff.dco));

   // scan sequencing
   always_comb begin
      scan_in = scan_ff;
      n_in    = n_ff;
      k_in    = k_ff;
      if (start) begin
         scan_in = 1'b1;
         n_in    = ods_pkg::N1_FIRST;
         k_in    = 3'd0;
      end else if (scan_ff) begin
         if (last_pair) begin
            scan_in = 1'b0;
         end else if (k_ff == ods_pkg::HS_LAST) begin
            k_in = 3'd0;
            n_in = (n_ff == ods_pkg::N1_FIRST) ? 8'd2 : n_ff + 8'd2;
         end else begin
            k_in = k_ff + 3'd1;
         end
      end
   end

   // best pair tracking; earlier pair wins a tie through the strict compare
   always_comb begin
      best_in = best_ff;
      done_in = 1'b0;
      if (start) begin
         best_in = '0;
      end else if (b_vld_ff) begin
         if (in_window && better) begin
            best_in.found = 1'b1;
            best_in.hs    = b_hs_ff;
            best_in.n1    = b_n1_ff;
            best_in.dco   = b_dco_ff[ods_pkg::DCO_W-1:0];
         end
         done_in = b_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff  <= 1'b0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         done_ff  <= 1'b0;
         best_ff  <= '0;
      end else begin
         scan_ff  <= scan_in;
         a_vld_ff <= scan_ff;
         b_vld_ff <= a_vld_ff;
         done_ff  <= done_in;
         best_ff  <= best_in;
      end
   end

   // payload path, no reset
   always_ff @(posedge clock) begin
      if (start) begin
         target_ff <= target_freq;
      end
      n_ff      <= n_in;
      k_ff      <= k_in;
      a_last_ff <= last_pair;
      a_mult_ff <= mult_full[ods_pkg::MULT_W-1:0];
      a_hs_ff   <= hs_cur;
      a_n1_ff   <= n_ff;
      b_last_ff <= a_last_ff;
      b_dco_ff  <= ods_pkg::PROD_W'(target_ff) * ods_pkg::PROD_W'(a_mult_ff);
      b_hs_ff   <= a_hs_ff;
      b_n1_ff   <= a_n1_ff;
   end

   assign done = done_ff;
   assign best = best_ff;

endmodule

/* rtl/ods_divider.sv */
// Restoring divider, one quotient bit per cycle: floor(dco * 2^31 / xtal)
// saturated to 38 bits. Depends on ods_pkg.
module ods_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ods_pkg::DCO_W-1:0]       dividend,
   input  logic [ods_pkg::XTAL_W-1:0]      divisor,
   output logic                            done,
   output logic [ods_pkg::RFREQ_W-1:0]     quotient
);

   localparam int NUM_W = ods_pkg::DCO_W + ods_pkg::FRAC_SHIFT;
   localparam int CNT_W = $clog2(NUM_W);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [NUM_W-1:0]              num_ff, num_in;
   logic [ods_pkg::XTAL_W-1:0]    rem_ff, rem_in;
   logic [ods_pkg::XTAL_W-1:0]    div_ff, div_in;
   logic [ods_pkg::RFREQ_W-1:0]   quo_ff, quo_in;

   logic [ods_pkg::XTAL_W:0]      trial;
   logic                          fits;
   logic                          saturate;

   // quotient reaches 2^38 exactly when dividend / divisor >= 128
   assign saturate = ({5'd0, dividend} >= {divisor, 7'd0});
   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign fits     = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         div_in = divisor;
         num_in = {dividend, ods_pkg::FRAC_SHIFT'(0)};
         rem_in = '0;
         cnt_in = '0;
         if (saturate) begin
            quo_in  = '1;
            done_in = 1'b1;
         end else begin
            quo_in = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         // one shift-subtract step
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         rem_in = fits ? ods_pkg::XTAL_W'(trial - {1'b0, div_ff}) : trial[ods_pkg::XTAL_W-1:0];
         quo_in = {quo_ff[ods_pkg::RFREQ_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/oscillator_divider_search.sv */
// Top level of the oscillator divider search: request/response sequencer
// and crystal register. Depends on ods_pkg, ods_search and ods_divider.
//
// A request on start is taken while busy is low. The scan issues one of the
// 390 (HS, N1) pairs per cycle into a single multiplier pipeline; when a pair
// fits, the RFREQ division then yields one quotient bit per cycle, or skips its
// shift-subtract steps when the quotient saturates. busy stays high for the
// whole request. The result is shown for exactly one cycle with rsp_valid and
// cannot be held off; it is registered, so the receiver must take it in that
// cycle. The crystal register is written through csr_valid/csr_ready at any
// time the block is idle; ready is always high.
module oscillator_divider_search (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [ods_pkg::TARGET_W-1:0]  req_target_freq,
   // response
   output logic                          rsp_valid,
   output logic                          rsp_found,
   output logic [ods_pkg::HS_W-1:0]      rsp_hs_divider,
   output logic [ods_pkg::N1_W-1:0]      rsp_n1_divider,
   output logic [ods_pkg::DCO_W-1:0]     rsp_dco_freq,
   output logic [ods_pkg::RFREQ_W-1:0]   rsp_rfreq_word,
   // crystal register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ods_pkg::XTAL_W-1:0]    csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [ods_pkg::XTAL_W-1:0]   xtal_ff;
   logic                         accept;

   logic                         search_done;
   ods_pkg::best_type            best;
   logic                         div_start;
   logic                         div_done;
   logic [ods_pkg::RFREQ_W-1:0]  div_quo;

   logic                         vld_ff, vld_in;
   ods_pkg::best_type            res_ff, res_in;
   logic [ods_pkg::RFREQ_W-1:0]  rfreq_ff, rfreq_in;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // crystal register
   always_ff @(posedge clock) begin
      if (reset) begin
         xtal_ff <= ods_pkg::XTAL_RESET;
      end else if (csr_valid && csr_ready) begin
         xtal_ff <= csr_data;
      end
   end

   ods_search u_search (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .target_freq (req_target_freq),
      .done        (search_done),
      .best        (best)
   );

   ods_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (best.dco),
      .divisor  (xtal_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // request sequencer
   always_comb begin
      state_in  = state_ff;
      div_start = 1'b0;
      vld_in    = 1'b0;
      res_in    = res_ff;
      rfreq_in  = rfreq_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (search_done) begin
               if (best.found) begin
                  div_start = 1'b1;
                  state_in  = ST_DIVIDE;
               end else begin
                  // no pair fits: all fields zero
                  res_in   = '0;
                  rfreq_in = '0;
                  vld_in   = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_in   = best;
               rfreq_in = div_quo;
               vld_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      rfreq_ff <= rfreq_in;
   end

   assign rsp_valid      = vld_ff;
   assign rsp_found      = res_ff.found;
   assign rsp_hs_divider = res_ff.hs;
   assign rsp_n1_divider = res_ff.n1;
   assign rsp_dco_freq   = res_ff.dco;
   assign rsp_rfreq_word = rfreq_ff;

   // a transaction starts a request that stays busy until its result
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but block not busy");

   // result strobe lasts one cycle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // a miss reports all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_hs_divider == '0 && rsp_n1_divider == '0 &&
                                     rsp_dco_freq == '0 && rsp_rfreq_word == '0))
      else $error("miss with nonzero fields");

   // a hit lies inside the DCO window
   a_hit_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (ods_pkg::PROD_W'(rsp_dco_freq) >= ods_pkg::DCO_MIN &&
          ods_pkg::PROD_W'(rsp_dco_freq) <= ods_pkg::DCO_MAX))
      else $error("reported DCO outside window");

endmodule
